// ===== rtl/sha1_message_digest_macros.svh =====
// ----------------------------------------------------------------------------
// SHA-1 message digest: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

// same-cycle implication
`define SHA1_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SHA1_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Constants, codes, controller/datapath types and round functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

	localparam int unsigned NUM_CHAIN = 5;
	localparam int unsigned NUM_SCHED = 16;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [2:0] LAST_IDX = 3'd4;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	localparam logic [31:0] H_INIT [NUM_CHAIN] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_LAST = 2'd1,
		KIND_END  = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		SEL_IN,
		SEL_PAD80,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic      put;
		byte_sel_t byte_sel;
		logic      count;
		logic      load_work;
		logic      round_step;
		logic      fold;
		logic      emit;
		logic [2:0] emit_idx;
		logic      clear;
	} cmd_t;

	typedef struct packed {
		logic pos_end;
		logic pos_len;
		logic round_last;
		logic out_free;
	} status_t;

	function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] r;
		if (rnd < 7'd20) begin
			r = (b & c) | (~b & d);
		end else if (rnd < 7'd40) begin
			r = b ^ c ^ d;
		end else if (rnd < 7'd60) begin
			r = (b & c) | (b & d) | (c & d);
		end else begin
			r = b ^ c ^ d;
		end
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] rnd);
		logic [31:0] r;
		if (rnd < 7'd20) begin
			r = K0;
		end else if (rnd < 7'd40) begin
			r = K1;
		end else if (rnd < 7'd60) begin
			r = K2;
		end else begin
			r = K3;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sha1_if.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message digest channel interfaces
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface sha1_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/sha1_dp.sv =====
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Byte packing, message schedule window, round unit, chaining words,
// bit count and the digest output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sha1_pkg::cmd_t  cmd,
	output sha1_pkg::status_t    status,
	input  wire logic [7:0]      in_byte,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [31:0]          out_word,
	output logic [2:0]           out_idx,
	output logic                 out_last
);

	logic [31:0] win_q   [sha1_pkg::NUM_SCHED];
	logic [31:0] chain_q [sha1_pkg::NUM_CHAIN];
	logic [31:0] work_q  [sha1_pkg::NUM_CHAIN];
	logic [5:0]  pos_q;
	logic [6:0]  round_q;
	logic [63:0] bit_cnt_q;
	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_idx_q;
	logic        out_last_q;

	logic [63:0] len_shift;
	logic [7:0]  put_val;
	logic [31:0] sched_new;
	logic [31:0] t_sum;
	logic [31:0] sel_chain;

	assign len_shift = bit_cnt_q << {pos_q[2:0], 3'b000};

	always_comb begin
		unique case (cmd.byte_sel)
			sha1_pkg::SEL_IN:    put_val = in_byte;
			sha1_pkg::SEL_PAD80: put_val = sha1_pkg::PAD_BYTE;
			sha1_pkg::SEL_ZERO:  put_val = 8'h00;
			sha1_pkg::SEL_LEN:   put_val = len_shift[63:56];
			default:             put_val = 8'h00;
		endcase
	end

	always_comb begin
		sched_new = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
		sched_new = {sched_new[30:0], sched_new[31]};
		t_sum = {work_q[0][26:0], work_q[0][31:27]}
			+ sha1_pkg::round_f(round_q, work_q[1], work_q[2], work_q[3])
			+ work_q[4] + sha1_pkg::round_k(round_q) + win_q[0];
	end

	always_comb begin
		unique case (cmd.emit_idx)
			3'd0:    sel_chain = chain_q[0];
			3'd1:    sel_chain = chain_q[1];
			3'd2:    sel_chain = chain_q[2];
			3'd3:    sel_chain = chain_q[3];
			3'd4:    sel_chain = chain_q[4];
			default: sel_chain = chain_q[0];
		endcase
	end

	// schedule window: packs bytes, then slides one word per round
	always_ff @(posedge clk) begin
		if (cmd.put) begin
			if (pos_q[1:0] == 2'b00) begin
				for (int i = 0; i < 15; i++) begin
					win_q[i] <= win_q[i + 1];
				end
				win_q[15] <= {24'h000000, put_val};
			end else begin
				win_q[15] <= {win_q[15][23:0], put_val};
			end
		end else if (cmd.round_step) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= sched_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_work) begin
			for (int i = 0; i < 5; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (cmd.round_step) begin
			work_q[4] <= work_q[3];
			work_q[3] <= work_q[2];
			work_q[2] <= {work_q[1][1:0], work_q[1][31:2]};
			work_q[1] <= work_q[0];
			work_q[0] <= t_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= sha1_pkg::H_INIT[i];
			end
			pos_q     <= '0;
			round_q   <= '0;
			bit_cnt_q <= '0;
		end else begin
			if (cmd.put) begin
				pos_q <= pos_q + 6'd1;
			end
			if (cmd.count) begin
				bit_cnt_q <= bit_cnt_q + 64'd8;
			end
			if (cmd.round_step) begin
				round_q <= round_q + 7'd1;
			end
			if (cmd.fold) begin
				round_q <= '0;
				for (int i = 0; i < 5; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end
			if (cmd.clear) begin
				bit_cnt_q <= '0;
				for (int i = 0; i < 5; i++) begin
					chain_q[i] <= sha1_pkg::H_INIT[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_word_q <= sel_chain;
			out_idx_q  <= cmd.emit_idx;
			out_last_q <= (cmd.emit_idx == sha1_pkg::LAST_IDX);
		end
	end

	assign status.pos_end    = (pos_q == 6'd63);
	assign status.pos_len    = (pos_q == 6'd56);
	assign status.round_last = (round_q == sha1_pkg::LAST_ROUND);
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_idx   = out_idx_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/sha1_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte intake, padding, the 80 rounds, the chaining update
// and the emission of the five digest words.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha1_message_digest_macros.svh"

module sha1_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [1:0]        in_kind,
	output logic                   in_ready,
	output sha1_pkg::cmd_t         cmd,
	input  wire sha1_pkg::status_t status
);

	sha1_pkg::state_t state_q;
	sha1_pkg::state_t state_d;
	logic       pad_q;
	logic       first_q;
	logic       len_q;
	logic [2:0] idx_q;

	logic has_byte;
	logic ends_msg;

	assign has_byte = (in_kind == sha1_pkg::KIND_DATA) || (in_kind == sha1_pkg::KIND_LAST);
	assign ends_msg = (in_kind == sha1_pkg::KIND_LAST) || (in_kind == sha1_pkg::KIND_END);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha1_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (has_byte && status.pos_end) begin
						state_d = sha1_pkg::ST_ROUND;
					end else if (ends_msg) begin
						state_d = sha1_pkg::ST_PAD;
					end
				end
			end
			sha1_pkg::ST_PAD: begin
				if (status.pos_end) begin
					state_d = sha1_pkg::ST_ROUND;
				end
			end
			sha1_pkg::ST_ROUND: begin
				if (status.round_last) begin
					state_d = sha1_pkg::ST_FOLD;
				end
			end
			sha1_pkg::ST_FOLD: begin
				if (pad_q && len_q) begin
					state_d = sha1_pkg::ST_OUT;
				end else if (pad_q) begin
					state_d = sha1_pkg::ST_PAD;
				end else begin
					state_d = sha1_pkg::ST_IDLE;
				end
			end
			sha1_pkg::ST_OUT: begin
				if (status.out_free && idx_q == sha1_pkg::LAST_IDX) begin
					state_d = sha1_pkg::ST_IDLE;
				end
			end
			default: state_d = sha1_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.byte_sel = sha1_pkg::SEL_IN;
		in_ready     = 1'b0;
		unique case (state_q)
			sha1_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && has_byte) begin
					cmd.put       = 1'b1;
					cmd.count     = 1'b1;
					cmd.load_work = status.pos_end;
				end
			end
			sha1_pkg::ST_PAD: begin
				cmd.put       = 1'b1;
				cmd.load_work = status.pos_end;
				if (first_q) begin
					cmd.byte_sel = sha1_pkg::SEL_PAD80;
				end else if (len_q || status.pos_len) begin
					cmd.byte_sel = sha1_pkg::SEL_LEN;
				end else begin
					cmd.byte_sel = sha1_pkg::SEL_ZERO;
				end
			end
			sha1_pkg::ST_ROUND: begin
				cmd.round_step = 1'b1;
			end
			sha1_pkg::ST_FOLD: begin
				cmd.fold = 1'b1;
			end
			sha1_pkg::ST_OUT: begin
				cmd.emit_idx = idx_q;
				if (status.out_free) begin
					cmd.emit  = 1'b1;
					cmd.clear = (idx_q == sha1_pkg::LAST_IDX);
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1_pkg::ST_IDLE;
			pad_q   <= 1'b0;
			first_q <= 1'b0;
			len_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sha1_pkg::ST_IDLE && in_valid && ends_msg) begin
				pad_q   <= 1'b1;
				first_q <= 1'b1;
				len_q   <= 1'b0;
			end
			if (state_q == sha1_pkg::ST_PAD) begin
				first_q <= 1'b0;
				if (!first_q && status.pos_len) begin
					len_q <= 1'b1;
				end
			end
			if (state_q == sha1_pkg::ST_OUT && status.out_free) begin
				if (idx_q == sha1_pkg::LAST_IDX) begin
					idx_q <= '0;
					pad_q <= 1'b0;
					len_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	`SHA1_ASSERT_NEXT(a_round_to_fold, state_q == sha1_pkg::ST_ROUND && status.round_last, state_q == sha1_pkg::ST_FOLD, "last round not followed by chaining update")
	`SHA1_ASSERT_NEXT(a_last_word_idle, state_q == sha1_pkg::ST_OUT && status.out_free && idx_q == sha1_pkg::LAST_IDX, state_q == sha1_pkg::ST_IDLE && !pad_q, "digest end did not return to idle")
	`SHA1_ASSERT_NOW(a_pad_flag, state_q == sha1_pkg::ST_PAD || state_q == sha1_pkg::ST_OUT, pad_q, "padding or output without message end")
	`SHA1_ASSERT_NOW(a_len_in_pad, len_q, pad_q, "length phase outside padding")

endmodule

`default_nettype wire

// ===== rtl/sha1_message_digest.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Absorbs a message byte by byte and returns the 160-bit digest as five
// 32-bit words, most significant first.
// ----------------------------------------------------------------------------
//  channel | dir | words             | payload
//  msg     | in  | one message byte  | kind, data_byte
//  digest  | out | one digest word   | digest_word, word_index, last_word
//
//  A byte that does not fill a block is taken without a stall.
//  The 64th byte of a block starts compression: 80 rounds on the shared round
//  unit, one per cycle, then the chaining update.
//  Message end: pad bytes (up to 72), one per cycle, plus one or two blocks,
//  then five digest words, one per cycle while the digest side takes them.
//  Reset loads the initial chaining words; no clearing pass is needed.
//  msg.ready is low while padding, while a block is compressed or while the digest is emitted.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_message_digest (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sha1_in_if.sink    msg,
	sha1_out_if.source digest
);

	sha1_pkg::cmd_t    cmd;
	sha1_pkg::status_t status;

	sha1_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (msg.valid),
		.in_kind  (msg.kind),
		.in_ready (msg.ready),
		.cmd      (cmd),
		.status   (status)
	);

	sha1_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_byte   (msg.data_byte),
		.out_valid (digest.valid),
		.out_ready (digest.ready),
		.out_word  (digest.digest_word),
		.out_idx   (digest.word_index),
		.out_last  (digest.last_word)
	);

endmodule

`default_nettype wire
